FILE: design/mtmp_pkg.sv
// Shared types, constants and the hex digit decoder for the magic packet builder.
`timescale 1ns / 1ps
package mtmp_pkg;

	// Width of one packet word (six bytes)
	localparam int WORD_W = 48;
	// Width of a MAC nibble
	localparam int NIB_W = 4;
	// Width of the digit counter, which saturates at COUNT_MAX
	localparam int CNT_W = 4;

	localparam logic [CNT_W-1:0] DIGITS_NEEDED = 4'd12;
	localparam logic [CNT_W-1:0] COUNT_MAX = 4'd13;

	// Default number of MAC copies after the sync word
	localparam int COPIES_DEF = 16;

	// Decoded character: is_digit set for 0-9, a-f, A-F
	typedef struct packed {
		logic             is_digit;
		logic [NIB_W-1:0] nibble;
	} hex_digit_t;

	// Parser view of the text as it stands
	typedef struct packed {
		logic              mac_ok;
		logic [WORD_W-1:0] mac;
	} text_state_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.is_digit = 1'b1;
		d.nibble   = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.nibble = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			// letters a-f / A-F share the low bits: 1..6 maps to 10..15
			d.nibble = c[3:0] + 4'd9;
		end else begin
			d.is_digit = 1'b0;
		end
		return d;
	endfunction

endpackage

FILE: design/mtmp_parse.sv
// Character parser: shifts hex digits into the MAC register and counts them.
`timescale 1ns / 1ps
module mtmp_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  finish,
	input  logic [7:0]            ch,
	output mtmp_pkg::text_state_t text
);

	logic [mtmp_pkg::CNT_W-1:0]  digit_count_q;
	logic [mtmp_pkg::WORD_W-1:0] mac_shift_q;
	mtmp_pkg::hex_digit_t        dig;

	assign dig = mtmp_pkg::hex_decode(ch);

	// Shift and count on digits; finish starts a new text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			mac_shift_q   <= '0;
		end else if (finish) begin
			digit_count_q <= '0;
			mac_shift_q   <= '0;
		end else if (step && dig.is_digit) begin
			mac_shift_q <= {mac_shift_q[mtmp_pkg::WORD_W-mtmp_pkg::NIB_W-1:0], dig.nibble};
			if (digit_count_q != mtmp_pkg::COUNT_MAX) begin
				digit_count_q <= digit_count_q + 1'b1;
			end
		end
	end

	assign text.mac_ok = (digit_count_q == mtmp_pkg::DIGITS_NEEDED);
	assign text.mac    = mac_shift_q;

endmodule

FILE: design/mac_text_to_magic_packet.sv
// Top level: MAC text in, Wake-on-LAN magic packet words out.
`timescale 1ns / 1ps
// Takes one character per cycle; hex digits of either case build the MAC and
// anything else is skipped. An end-of-text transfer yields either 1 + COPIES
// words (all ones, then the MAC COPIES times, last set on the final one) or
// a single error word (zero, status 1, last 1). Characters are taken every
// cycle, even while a packet drains; an end-of-text transfer waits until the
// final word of the previous packet sits in the output register and leaves in
// that same cycle. The single output register sends one word per cycle while
// out_ready is high.
module mac_text_to_magic_packet #(
	parameter int COPIES = mtmp_pkg::COPIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  ch,
	input  logic                        end_of_text,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mtmp_pkg::WORD_W-1:0] word,
	output logic                        status,
	output logic                        last
);

	localparam int REM_W = $clog2(COPIES + 1);

	mtmp_pkg::text_state_t       text;
	logic [REM_W-1:0]            rem_q;
	logic [mtmp_pkg::WORD_W-1:0] burst_mac_q;
	logic                        out_valid_q;
	logic [mtmp_pkg::WORD_W-1:0] word_q;
	logic                        status_q;
	logic                        last_q;
	logic                        slot_free;
	logic                        in_xfer;
	logic                        eot_xfer;

	assign slot_free = !out_valid_q || out_ready;
	// Characters never wait; end of text needs an idle burst and a free slot
	assign in_ready  = !end_of_text || (rem_q == '0 && slot_free);
	assign in_xfer   = in_valid && in_ready;
	assign eot_xfer  = in_xfer && end_of_text;

	mtmp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_xfer && !end_of_text),
		.finish (eot_xfer),
		.ch     (ch),
		.text   (text)
	);

	// Burst control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (eot_xfer) begin
			out_valid_q <= 1'b1;
			rem_q       <= text.mac_ok ? REM_W'(COPIES) : '0;
		end else if (slot_free) begin
			out_valid_q <= (rem_q != '0);
			if (rem_q != '0) begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	// Payload of the output register
	always_ff @(posedge clk) begin
		if (eot_xfer) begin
			burst_mac_q <= text.mac;
			word_q      <= text.mac_ok ? {mtmp_pkg::WORD_W{1'b1}} : '0;
			status_q    <= !text.mac_ok;
			last_q      <= !text.mac_ok;
		end else if (slot_free && rem_q != '0) begin
			word_q   <= burst_mac_q;
			status_q <= 1'b0;
			last_q   <= (rem_q == REM_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign word      = word_q;
	assign status    = status_q;
	assign last      = last_q;

	// End of text is never taken while a packet still drains
	a_eot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		eot_xfer |-> rem_q == '0)
		else $error("end of text taken during a burst");

	// Every end-of-text transfer puts a result in the output register
	a_eot_result: assert property (@(posedge clk) disable iff (!arst_n)
		eot_xfer |=> out_valid_q)
		else $error("no result after end of text");

	// A pending burst always has a word waiting
	a_burst_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != '0 |-> out_valid_q && !last_q)
		else $error("burst pending without a held word");

	// Error results are single, zero and final
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> last_q && word_q == '0 && rem_q == '0)
		else $error("malformed error result");

endmodule

FILE: tb/magic_packet_checker.sv
// Checker for the magic packet builder: tracks MAC text transfers and checks every output word.
`timescale 1ns / 1ps
module magic_packet_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [7:0]                  ch,
	input  logic                        end_of_text,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [mtmp_pkg::WORD_W-1:0] word,
	input  logic                        status,
	input  logic                        last,
	output int                          fail_count,
	output int                          pending,
	output int                          packets_built,
	output int                          texts_rejected,
	output int                          words_checked
);

	typedef struct packed {
		logic [mtmp_pkg::WORD_W-1:0] word;
		logic                        status;
		logic                        last;
	} pkt_word_t;

	// Words still owed by the block, oldest first
	pkt_word_t                   pkt_words_due[$];
	// Parser state as the block should hold it
	logic [mtmp_pkg::CNT_W-1:0]  seen_digits;
	logic [mtmp_pkg::WORD_W-1:0] mac_acc;

	// Bit 4 set: not a hex digit; otherwise the low nibble is the digit value
	function automatic logic [4:0] char_nibble(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h10;
		if (c >= 8'h30 && c <= 8'h39)
			v = c - 8'h30;
		else if (c >= 8'h61 && c <= 8'h66)
			v = c - 8'h57;
		else if (c >= 8'h41 && c <= 8'h46)
			v = c - 8'h37;
		return v[4:0];
	endfunction

	// One character or end of text: update the parser, queue the words it owes
	task automatic predict_transfer(input logic [7:0] c, input logic eot);
		logic [4:0] h;
		pkt_word_t  w;
		h = char_nibble(c);
		if (!eot) begin
			if (!h[4]) begin
				mac_acc = {mac_acc[mtmp_pkg::WORD_W-mtmp_pkg::NIB_W-1:0], h[3:0]};
				if (seen_digits < mtmp_pkg::COUNT_MAX)
					seen_digits = seen_digits + 1'b1;
			end
		end else begin
			if (seen_digits != mtmp_pkg::DIGITS_NEEDED) begin
				w = '{word: '0, status: 1'b1, last: 1'b1};
				pkt_words_due.push_back(w);
				texts_rejected++;
			end else begin
				// sync word of all ones, then the MAC repeated
				w = '{word: '1, status: 1'b0, last: 1'b0};
				pkt_words_due.push_back(w);
				for (int i = 0; i < mtmp_pkg::COPIES_DEF; i++) begin
					w = '{word: mac_acc, status: 1'b0,
						last: (i == mtmp_pkg::COPIES_DEF - 1)};
					pkt_words_due.push_back(w);
				end
				packets_built++;
			end
			seen_digits = '0;
			mac_acc = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pkt_word_t exp_w;
		if (!arst_n) begin
			pkt_words_due.delete();
			seen_digits = '0;
			mac_acc = '0;
			fail_count = 0;
			packets_built = 0;
			texts_rejected = 0;
			words_checked = 0;
		end else begin
			if (in_valid && in_ready)
				predict_transfer(ch, end_of_text);
			// output transfer against the oldest owed word
			if (out_valid && out_ready) begin
				words_checked++;
				if (pkt_words_due.size() == 0) begin
					$error("unexpected output: word=%h status=%0b last=%0b", word, status, last);
					fail_count++;
				end else begin
					exp_w = pkt_words_due.pop_front();
					if (word !== exp_w.word) begin
						$error("word: expected %h, actual %h", exp_w.word, word);
						fail_count++;
					end
					if (status !== exp_w.status) begin
						$error("status: expected %0b, actual %0b", exp_w.status, status);
						fail_count++;
					end
					if (last !== exp_w.last) begin
						$error("last: expected %0b, actual %0b", exp_w.last, last);
						fail_count++;
					end
				end
			end
		end
		pending = pkt_words_due.size();
	end

endmodule

FILE: tb/mac_text_to_magic_packet_tb.sv
// Testbench top for the magic packet builder: clock, reset, MAC text stimulus and verdict.
`timescale 1ns / 1ps
module mac_text_to_magic_packet_tb;

	localparam int RANDOM_ITEMS = 95;
	localparam int HOLD_CYCLES = 120;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [7:0]                  ch;
	logic                        end_of_text;
	logic                        out_valid;
	logic                        out_ready;
	logic [mtmp_pkg::WORD_W-1:0] word;
	logic                        status;
	logic                        last;

	int fail_count;
	int pending;
	int packets_built;
	int texts_rejected;
	int words_checked;
	int items_sent;
	int cycles;
	bit tx_calm;
	bit rx_calm;

	mac_text_to_magic_packet u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ch          (ch),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.word        (word),
		.status      (status),
		.last        (last)
	);

	magic_packet_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ch             (ch),
		.end_of_text    (end_of_text),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.word           (word),
		.status         (status),
		.last           (last),
		.fail_count     (fail_count),
		.pending        (pending),
		.packets_built  (packets_built),
		.texts_rejected (texts_rejected),
		.words_checked  (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [7:0] random_hex_char();
		int idx;
		idx = $urandom_range(0, 21);
		if (idx < 10)
			return 8'(8'h30 + idx);
		else if (idx < 16)
			return 8'(8'h61 + idx - 10);
		return 8'(8'h41 + idx - 16);
	endfunction

	function automatic logic [7:0] random_separator();
		logic [7:0] b;
		logic [7:0] low;
		do begin
			b = 8'($urandom);
			low = b | 8'h20;
		end while ((b >= 8'h30 && b <= 8'h39) || (low >= 8'h61 && low <= 8'h66));
		return b;
	endfunction

	// One input transfer, after a random gap
	task automatic send_item(input logic [7:0] c, input logic eot);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ch <= c;
		end_of_text <= eot;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
		items_sent++;
		if ($urandom_range(0, 19) == 0)
			tx_calm = !tx_calm;
	endtask

	// n hex digits, separators sprinkled in, then end of text with a random char
	task automatic send_text(input int n_digits);
		logic [7:0] b;
		for (int i = 0; i < n_digits; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_item(random_separator(), 1'b0);
			send_item(random_hex_char(), 1'b0);
		end
		b = 8'($urandom);
		send_item(b, 1'b1);
	endtask

	// Output side: random stalls, plus one long hold-off after the first packet
	initial begin : sink
		int gap;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		rx_calm = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && words_checked >= mtmp_pkg::COPIES_DEF + 1) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = rx_calm ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
			if ($urandom_range(0, 24) == 0)
				rx_calm = !rx_calm;
		end
	end

	initial begin : stim
		int kind;
		int start_items;
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = 8'h00;
		end_of_text = 1'b0;
		tx_calm = 1'b0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Valid MAC: digit range ends of both cases, NUL and 0xFF as separators
		send_item("0", 1'b0);
		send_item("9", 1'b0);
		send_item(8'h00, 1'b0);
		send_item("a", 1'b0);
		send_item("f", 1'b0);
		send_item("A", 1'b0);
		send_item("F", 1'b0);
		send_item(8'hFF, 1'b0);
		send_item("5", 1'b0);
		send_item("c", 1'b0);
		send_item("E", 1'b0);
		send_item("3", 1'b0);
		send_item("7", 1'b0);
		send_item("b", 1'b0);
		send_item(8'h00, 1'b1);
		// Empty text: too few digits, char on end of text ignored
		send_item(8'hFF, 1'b1);
		// Thirteen digits: count saturates, error
		for (int i = 0; i < 13; i++)
			send_item(8'(8'h31 + (i % 9)), 1'b0);
		send_item("5", 1'b1);

		// Mostly well-formed texts with random content, some short/long/noise
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 6)
				send_text(12);
			else if (kind < 8)
				send_text($urandom_range(0, 11));
			else if (kind == 8)
				send_text($urandom_range(13, 16));
			else
				repeat ($urandom_range(1, 4)) send_item(8'($urandom), 1'b0);
		end
		// Close any text left open by noise
		send_item(8'h00, 1'b1);
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d input transfers: %0d magic packets, %0d rejected texts",
			items_sent, packets_built, texts_rejected);
		$display("checked %0d output words, %0d mismatches", words_checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
design/mtmp_pkg.sv
design/mtmp_parse.sv
design/mac_text_to_magic_packet.sv
tb/magic_packet_checker.sv
tb/mac_text_to_magic_packet_tb.sv
